FILE: rtl/dass_pkg.sv
package dass_pkg;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_LABEL = 3'd1,
      PH_SKIP  = 3'd2,
      PH_PTR   = 3'd3,
      PH_FIXED = 3'd4,
      PH_DATA  = 3'd5,
      PH_DONE  = 3'd6,
      PH_FAIL  = 3'd7
   } phase_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_BAD_LABEL = 2'd2;

   localparam logic [7:0]  LABEL_TOP_MASK = 8'hC0;
   localparam logic [3:0]  FIXED_LEN      = 4'd10;
   localparam logic [3:0]  TTL_FIRST      = 4'd4;
   localparam logic [3:0]  RDLEN_FIRST    = 4'd8;
   localparam logic [15:0] POS_LIMIT      = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] answer_start;
      logic [15:0] answer_count;
      logic        last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] end_offset;
      logic [31:0] min_ttl;
   } rsp_item_type;

   typedef struct packed {
      logic advance;
      logic emit;
   } step_ctl_type;

endpackage

FILE: rtl/dass_if.sv
interface dass_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic [15:0] answer_start;
   logic [15:0] answer_count;
   logic        last_byte;

   modport source (output valid, output data_byte, output first_byte,
                   output answer_start, output answer_count, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input first_byte,
                 input answer_start, input answer_count, input last_byte,
                 output ready);
endinterface

interface dass_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] end_offset;
   logic [31:0] min_ttl;

   modport source (output valid, output status, output end_offset, output min_ttl,
                   input ready);
   modport sink (input valid, input status, input end_offset, input min_ttl,
                 output ready);
endinterface

FILE: rtl/dass_in_stage.sv
module dass_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dass_pkg::req_item_type in_item,
   input  dass_pkg::step_ctl_type ctl,
   output logic                  item_valid,
   output dass_pkg::req_item_type item
);
   import dass_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign in_ready = !valid_ff || ctl.advance;
   assign take     = in_valid && in_ready;
   assign valid_in = take ? 1'b1 : (ctl.advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

FILE: rtl/dass_walker.sv
module dass_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  dass_pkg::req_item_type item,
   input  logic                   slot_free,
   output dass_pkg::step_ctl_type ctl,
   output dass_pkg::rsp_item_type result
);
   import dass_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] left_ff, left_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] skip_ff, skip_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [15:0] rdlen_ff, rdlen_in;
   logic [31:0] low_ff, low_in;
   logic        seen_ff, seen_in;
   logic [1:0]  err_ff, err_in;

   assign ctl.advance = item_valid && (!item.last_byte || slot_free);
   assign ctl.emit    = ctl.advance && item.last_byte;

   always_comb begin
      logic [7:0]  b;
      logic [15:0] cur_pos;
      logic        take_label;
      b          = item.data_byte;
      take_label = 1'b0;
      pos_in   = pos_ff;
      start_in = start_ff;
      left_in  = left_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      fidx_in  = fidx_ff;
      ttl_in   = ttl_ff;
      rdlen_in = rdlen_ff;
      low_in   = low_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;

      if (item.first_byte) begin
         pos_in   = '0;
         start_in = item.answer_start;
         left_in  = item.answer_count;
         phase_in = (item.answer_count == 16'd0) ? PH_DONE : PH_WAIT;
         skip_in  = '0;
         fidx_in  = '0;
         ttl_in   = '0;
         rdlen_in = '0;
         low_in   = '0;
         seen_in  = 1'b0;
         err_in   = STATUS_OK;
      end

      cur_pos = pos_in;
      if (cur_pos != POS_LIMIT) begin
         case (phase_in)
            PH_WAIT: begin
               if (left_in == 16'd0) begin
                  phase_in = PH_DONE;
               end else if (cur_pos >= start_in) begin
                  take_label = 1'b1;
               end
            end
            PH_LABEL: begin
               take_label = 1'b1;
            end
            PH_SKIP: begin
               skip_in = skip_in - 16'd1;
               if (skip_in == 16'd0) begin
                  phase_in = PH_LABEL;
               end
            end
            PH_PTR: begin
               phase_in = PH_FIXED;
               fidx_in  = '0;
            end
            PH_FIXED: begin
               if (fidx_in >= TTL_FIRST && fidx_in < RDLEN_FIRST) begin
                  ttl_in = {ttl_in[23:0], b};
               end else if (fidx_in >= RDLEN_FIRST) begin
                  rdlen_in = {rdlen_in[7:0], b};
               end
               fidx_in = fidx_in + 4'd1;
               if (fidx_in >= FIXED_LEN) begin
                  fidx_in = '0;
                  if (!seen_in || ttl_in < low_in) begin
                     low_in  = ttl_in;
                     seen_in = 1'b1;
                  end
                  if (rdlen_in == 16'd0) begin
                     left_in = left_in - 16'd1;
                     if (left_in == 16'd0) begin
                        phase_in = PH_DONE;
                        start_in = cur_pos + 16'd1;
                     end else begin
                        phase_in = PH_LABEL;
                     end
                  end else begin
                     skip_in  = rdlen_in;
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               skip_in = skip_in - 16'd1;
               if (skip_in == 16'd0) begin
                  left_in = left_in - 16'd1;
                  if (left_in == 16'd0) begin
                     phase_in = PH_DONE;
                     start_in = cur_pos + 16'd1;
                  end else begin
                     phase_in = PH_LABEL;
                  end
               end
            end
            default: begin
            end
         endcase

         if (take_label) begin
            if ((b & LABEL_TOP_MASK) == LABEL_TOP_MASK) begin
               phase_in = PH_PTR;
            end else if ((b & LABEL_TOP_MASK) != 8'h00) begin
               phase_in = PH_FAIL;
               err_in   = STATUS_BAD_LABEL;
            end else if (b == 8'h00) begin
               phase_in = PH_FIXED;
               fidx_in  = '0;
            end else begin
               phase_in = PH_SKIP;
               skip_in  = {8'h00, b};
            end
         end

         pos_in = cur_pos + 16'd1;
      end
   end

   always_comb begin
      if (phase_in == PH_DONE) begin
         result.status     = STATUS_OK;
         result.end_offset = start_in;
         result.min_ttl    = seen_in ? low_in : 32'd0;
      end else begin
         result.status     = (phase_in == PH_FAIL) ? err_in : STATUS_TRUNCATED;
         result.end_offset = '0;
         result.min_ttl    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         left_ff  <= '0;
         phase_ff <= PH_WAIT;
         skip_ff  <= '0;
         fidx_ff  <= '0;
         ttl_ff   <= '0;
         rdlen_ff <= '0;
         low_ff   <= '0;
         seen_ff  <= 1'b0;
         err_ff   <= STATUS_OK;
      end else if (ctl.advance) begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         left_ff  <= left_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         fidx_ff  <= fidx_in;
         ttl_ff   <= ttl_in;
         rdlen_ff <= rdlen_in;
         low_ff   <= low_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
      end
   end
endmodule

FILE: rtl/dass_out_stage.sv
module dass_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  dass_pkg::step_ctl_type ctl,
   input  dass_pkg::rsp_item_type result,
   output logic                   slot_free,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dass_pkg::rsp_item_type out_item
);
   import dass_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || out_ready;
   assign valid_in  = ctl.emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         item_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

FILE: rtl/dns_answer_section_scanner_top.sv
// DNS answer-section scanner.
// req_bus: one packet byte per transfer, with first_byte on offset zero
// (answer_start and answer_count are sampled only then) and last_byte on
// the final byte. rsp_bus: one result (status, end_offset, min_ttl) per
// byte that carries last_byte; other bytes give no transfer on rsp_bus.
// Throughput: one byte per cycle while req_bus.ready is high. Each byte is
// held in an input register and the walker state is updated from it when
// the walker steps; it loads the output register when it steps on last_byte.
// The output register frees req_bus from rsp_bus: bytes without last_byte
// keep flowing while a result waits. A byte with last_byte waits in the
// input register until the output register is empty or being read, and
// req_bus.ready drops only while such a byte is held.
// Reset (synchronous) empties both registers and returns the scan to the
// wait phase with no answer records left.
module dns_answer_section_scanner_top (
   input  logic      clock,
   input  logic      reset,
   dass_req_if.sink   req_bus,
   dass_rsp_if.source rsp_bus
);
   import dass_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   step_ctl_type ctl;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         slot_free;

   assign req_item.data_byte    = req_bus.data_byte;
   assign req_item.first_byte   = req_bus.first_byte;
   assign req_item.answer_start = req_bus.answer_start;
   assign req_item.answer_count = req_bus.answer_count;
   assign req_item.last_byte    = req_bus.last_byte;

   dass_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_item    (req_item),
      .ctl        (ctl),
      .item_valid (item_valid),
      .item       (item)
   );

   dass_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .slot_free  (slot_free),
      .ctl        (ctl),
      .result     (result)
   );

   dass_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .result    (result),
      .slot_free (slot_free),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

   assign rsp_bus.status     = rsp_item.status;
   assign rsp_bus.end_offset = rsp_item.end_offset;
   assign rsp_bus.min_ttl    = rsp_item.min_ttl;
endmodule
